// ----- design/aessbox_pkg.sv -----
package aessbox_pkg;

   typedef logic [7:0] basis_type [8];

   // Columns of the basis-change matrices; entry 0 is selected by the MSB.
   localparam basis_type STD_TO_TOWER = '{8'd152, 8'd243, 8'd242, 8'd72,
                                          8'd9,   8'd129, 8'd169, 8'd255};
   localparam basis_type TOWER_TO_SBOX = '{8'd88,  8'd45, 8'd158, 8'd11,
                                           8'd220, 8'd4,  8'd3,   8'd36};

   localparam logic [7:0] SBOX_AFFINE_CONST = 8'h63;

   // GF(2^2) helpers
   function automatic logic [1:0] f4_mult(logic [1:0] u, logic [1:0] v);
      logic m;
      m = (u[1] ^ u[0]) & (v[1] ^ v[0]);
      return {(u[1] & v[1]) ^ m, (u[0] & v[0]) ^ m};
   endfunction

   function automatic logic [1:0] f4_scale_n(logic [1:0] u);
      return {u[0], u[1] ^ u[0]};
   endfunction

   function automatic logic [1:0] f4_scale_n2(logic [1:0] u);
      return {u[1] ^ u[0], u[1]};
   endfunction

   function automatic logic [1:0] f4_square(logic [1:0] u);
      return {u[0], u[1]};
   endfunction

   // GF(2^4) helpers
   function automatic logic [3:0] f16_mult(logic [3:0] u, logic [3:0] v);
      logic [1:0] m;
      m = f4_scale_n(f4_mult(u[3:2] ^ u[1:0], v[3:2] ^ v[1:0]));
      return {f4_mult(u[3:2], v[3:2]) ^ m, f4_mult(u[1:0], v[1:0]) ^ m};
   endfunction

   function automatic logic [3:0] f16_square_scale(logic [3:0] u);
      return {f4_square(u[3:2] ^ u[1:0]), f4_scale_n2(f4_square(u[1:0]))};
   endfunction

   function automatic logic [3:0] f16_invert(logic [3:0] u);
      logic [1:0] s;
      logic [1:0] pr;
      logic [1:0] iv;
      s  = f4_scale_n(f4_square(u[3:2] ^ u[1:0]));
      pr = f4_mult(u[3:2], u[1:0]);
      iv = f4_square(s ^ pr);
      return {f4_mult(iv, u[1:0]), f4_mult(iv, u[3:2])};
   endfunction

   // GF(2^8) inverse in tower form; zero maps to zero
   function automatic logic [7:0] f256_invert(logic [7:0] u);
      logic [3:0] s;
      logic [3:0] pr;
      logic [3:0] iv;
      s  = f16_square_scale(u[7:4] ^ u[3:0]);
      pr = f16_mult(u[7:4], u[3:0]);
      iv = f16_invert(s ^ pr);
      return {f16_mult(iv, u[3:0]), f16_mult(iv, u[7:4])};
   endfunction

   // Bit j of u selects column 7 - j
   function automatic logic [7:0] basis_change(logic [7:0] u, basis_type cols);
      logic [7:0] acc;
      acc = '0;
      for (int j = 0; j < 8; j++) begin
         if (u[j]) begin
            acc ^= cols[3'(7 - j)];
         end
      end
      return acc;
   endfunction

endpackage

// ----- design/aes_sbox_tower_field.sv -----
// AES forward S-box, composite-field (tower) implementation.
// An accepted word is held in the input register, then moves to the result register that drives rsp_ once it is free.
// Throughput: one word per cycle; only rsp_stall holds the pipe back.
// Reset: synchronous, active high; clears both valid flags, payload is not reset.
// No state is kept between words.
module aes_sbox_tower_field (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte
);

   // Input stage
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;

   // Result stage
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_byte_ff;

   logic       rsp_free;    // result register can take a word this cycle
   logic       in_move;     // input stage hands its word to the result stage
   logic       req_take;    // a new word is accepted
   logic [7:0] tower_byte;  // input in tower basis
   logic [7:0] tower_inv;   // inverse in tower basis
   logic [7:0] sbox_byte;   // final substitution

   // The result register frees up when empty or when its word is taken.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign in_move  = in_valid_ff && rsp_free;

   // The input register takes a word when empty or when it is emptying.
   assign req_stall = in_valid_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;

   // Datapath: basis change, tower inversion, back to standard basis with
   // the linear part of the affine map folded in, then the affine constant.
   always_comb begin
      tower_byte = aessbox_pkg::basis_change(in_byte_ff, aessbox_pkg::STD_TO_TOWER);
      tower_inv  = aessbox_pkg::f256_invert(tower_byte);
      sbox_byte  = aessbox_pkg::basis_change(tower_inv, aessbox_pkg::TOWER_TO_SBOX)
                   ^ aessbox_pkg::SBOX_AFFINE_CONST;
   end

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !in_move);
      rsp_valid_in = in_move || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, enabled only; a stalled word holds
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
      if (in_move) begin
         rsp_byte_ff <= sbox_byte;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

endmodule

// ----- design/aessbox_chk.sv -----
module aessbox_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte
);

   // Nothing comes out in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // Input is only held off by a result word stuck downstream.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without downstream back-pressure");

   // An accepted word passes the input register and reaches the output if the output is free.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted word not delivered on time");

   // A stalled result word stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled result word keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_out_byte))
      else $error("rsp_out_byte changed while stalled");

endmodule

bind aes_sbox_tower_field aessbox_chk u_aessbox_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte)
);
